/* src/flcs_pkg.sv */
// Shared types, constants and helper functions for the fiber laser command sequencer.
package flcs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned POWER_W         = 8;
  localparam int unsigned MODE_W          = 4;
  localparam int unsigned TICK_W          = 20;
  localparam int unsigned STEP_W          = 3;
  localparam int unsigned FLAG_W          = 5;
  localparam int unsigned CMD_W           = 2;
  localparam int unsigned QCOUNT_W        = 5;
  localparam int unsigned STATUS_W        = 7;
  localparam int unsigned PADDR_W         = 5;
  localparam int unsigned PDATA_W         = 32;
  localparam int unsigned S_TDATA_W       = 16;
  localparam int unsigned M_TDATA_W       = 32;
  localparam int unsigned RES_W           = 27;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK,
    CMD_REQUEST,
    CMD_STOP,
    CMD_CLEAR_STOP
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE,
    MODE_CHANGE_POWER,
    MODE_POWER_ON,
    MODE_POWER_OFF,
    MODE_EMISSION_ON,
    MODE_EMISSION_OFF,
    MODE_POINTER_ON,
    MODE_POINTER_OFF,
    MODE_ESTOP_ON,
    MODE_ESTOP_OFF
  } mode_e;

  typedef enum logic [2:0] {
    REG_OSC_TO_EM,
    REG_EM_TO_OSC,
    REG_LATCH_SETUP,
    REG_LATCH_HOLD,
    REG_LATCH_GAP,
    REG_MIN_GAP
  } reg_e;

  // Sequence step codes
  localparam logic [STEP_W-1:0] STEP_FREE         = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SINGLE       = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LATCH_GAP    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LATCH_FALL   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_LATCH_RISE   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_BUS_WRITE    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_ONOFF_FIRST  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ONOFF_SECOND = 3'd2;

  localparam logic [POWER_W-1:0] MAX_POWER       = 8'd247;
  localparam logic [POWER_W-1:0] MIN_POWER       = 8'd25;
  localparam logic [POWER_W-1:0] LOW_POWER_LIMIT = 8'd51;

  // laser flag bits
  localparam int unsigned FL_OSC  = 0;
  localparam int unsigned FL_EM   = 1;
  localparam int unsigned FL_PTR  = 2;
  localparam int unsigned FL_STOP = 3;
  localparam int unsigned FL_SETP = 4;

  typedef struct packed {
    logic [TICK_W-1:0] osc_to_em;
    logic [TICK_W-1:0] em_to_osc;
    logic [TICK_W-1:0] latch_setup;
    logic [TICK_W-1:0] latch_hold;
    logic [TICK_W-1:0] latch_gap;
    logic [TICK_W-1:0] min_gap;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    osc_to_em:   20'd5000,
    em_to_osc:   20'd1,
    latch_setup: 20'd4,
    latch_hold:  20'd4,
    latch_gap:   20'd0,
    min_gap:     20'd0
  };

  typedef struct packed {
    cmd_e               cmd;
    logic [MODE_W-1:0]  mode;
    logic [POWER_W-1:0] power;
    logic               alarm_a;
    logic               alarm_b;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [POWER_W-1:0] power;
  } entry_t;

  function automatic logic [POWER_W-1:0] map_power(input logic [POWER_W-1:0] raw);
    logic [POWER_W-1:0] p;
    if (raw == '0) begin
      p = MIN_POWER;
    end else if (raw > MAX_POWER) begin
      p = MAX_POWER;
    end else if (raw < LOW_POWER_LIMIT) begin
      p = (raw >> 1) + MIN_POWER;
    end else begin
      p = raw;
    end
    return p;
  endfunction

  function automatic logic [STEP_W-1:0] start_step(input logic [MODE_W-1:0] mode);
    logic [STEP_W-1:0] s;
    if (mode == MODE_CHANGE_POWER) begin
      s = STEP_BUS_WRITE;
    end else if (mode == MODE_POWER_ON || mode == MODE_POWER_OFF) begin
      s = STEP_ONOFF_FIRST;
    end else begin
      s = STEP_SINGLE;
    end
    return s;
  endfunction

endpackage

/* src/flcs_cfg.sv */
// Configuration register file behind the APB-style port.
module flcs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [flcs_pkg::PADDR_W-1:0]   paddr,
  input  logic [flcs_pkg::PDATA_W-1:0]   pwdata,
  output logic [flcs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output flcs_pkg::cfg_t                 cfg_o
);
  import flcs_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic              wr_en;
  reg_e              sel;
  logic [TICK_W-1:0] wval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_e'(paddr[PADDR_W-1:2]);
  assign wval   = pwdata[TICK_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_OSC_TO_EM:   cfg_d.osc_to_em   = wval;
        REG_EM_TO_OSC:   cfg_d.em_to_osc   = wval;
        REG_LATCH_SETUP: cfg_d.latch_setup = wval;
        REG_LATCH_HOLD:  cfg_d.latch_hold  = wval;
        REG_LATCH_GAP:   cfg_d.latch_gap   = wval;
        REG_MIN_GAP:     cfg_d.min_gap     = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_OSC_TO_EM:   prdata = PDATA_W'(cfg_q.osc_to_em);
      REG_EM_TO_OSC:   prdata = PDATA_W'(cfg_q.em_to_osc);
      REG_LATCH_SETUP: prdata = PDATA_W'(cfg_q.latch_setup);
      REG_LATCH_HOLD:  prdata = PDATA_W'(cfg_q.latch_hold);
      REG_LATCH_GAP:   prdata = PDATA_W'(cfg_q.latch_gap);
      REG_MIN_GAP:     prdata = PDATA_W'(cfg_q.min_gap);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/flcs_fifo.sv */
// Request queue storage with a registered, write-through head read.
module flcs_fifo #(
  parameter  int unsigned DEPTH = flcs_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [PTR_W-1:0]     waddr_i,
  input  flcs_pkg::entry_t     wdata_i,
  input  logic [PTR_W-1:0]     raddr_i,
  output flcs_pkg::entry_t     rdata_o
);
  import flcs_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/flcs_core.sv */
// Request filter, queue control and pin sequencer, one item per enabled cycle.
module flcs_core #(
  parameter  int unsigned DEPTH = flcs_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  flcs_pkg::item_t             item_i,
  input  flcs_pkg::cfg_t              cfg_i,
  input  flcs_pkg::entry_t            head_i,
  output logic                        we_o,
  output logic [PTR_W-1:0]            waddr_o,
  output flcs_pkg::entry_t            wdata_o,
  output logic [PTR_W-1:0]            raddr_o,
  output logic [flcs_pkg::RES_W-1:0]  result_o
);
  import flcs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W:0]   DEPTH_S = (CNT_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  logic [TICK_W-1:0]  wait_q, wait_d;
  mode_e              mode_q, mode_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [POWER_W-1:0] power_q, power_d;
  logic [FLAG_W-1:0]  flags_q, flags_d;
  logic [MODE_W-1:0]  last_mode_q, last_mode_d;
  logic [POWER_W-1:0] last_power_q, last_power_d;
  logic               blocked_q, blocked_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [POWER_W-1:0] bus_q, bus_d;
  logic               latch_q, latch_d;

  logic [POWER_W-1:0] mapped;
  logic [TICK_W-1:0]  gap;
  logic [CNT_W:0]     tail_sum;
  logic [CNT_W:0]     tail;
  logic [PTR_W-1:0]   head_inc;
  logic               run, push, dropped, fire_en, done;
  mode_e              f_mode;
  logic [STEP_W-1:0]  f_step;

  assign mapped   = map_power(item_i.power);
  assign gap      = (cfg_i.min_gap == '0) ? TICK_W'(1) : cfg_i.min_gap;
  assign tail_sum = {{(CNT_W + 1 - PTR_W){1'b0}}, head_q} + {1'b0, count_q};
  assign tail     = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
  assign head_inc = (head_q == LAST_P) ? '0 : head_q + 1'b1;

  always_comb begin
    wait_d       = wait_q;
    mode_d       = mode_q;
    step_d       = step_q;
    power_d      = power_q;
    flags_d      = flags_q;
    last_mode_d  = last_mode_q;
    last_power_d = last_power_q;
    blocked_d    = blocked_q;
    count_d      = count_q;
    head_d       = head_q;
    bus_d        = bus_q;
    latch_d      = latch_q;
    run          = 1'b0;
    push         = 1'b0;
    dropped      = 1'b0;
    fire_en      = 1'b0;
    done         = 1'b0;
    f_mode       = mode_q;
    f_step       = step_q;

    case (item_i.cmd)
      CMD_TICK: begin
        if (step_q != STEP_FREE) begin
          if (wait_q > TICK_W'(1)) begin
            wait_d = wait_q - TICK_W'(1);
          end else begin
            wait_d = '0;
            if (mode_q == MODE_IDLE) begin
              step_d = STEP_FREE;
              if ((count_q != '0) && !blocked_q) begin
                head_d  = head_inc;
                count_d = count_q - 1'b1;
                mode_d  = mode_e'(head_i.mode);
                power_d = head_i.power;
                f_mode  = mode_e'(head_i.mode);
                f_step  = start_step(head_i.mode);
                fire_en = 1'b1;
              end
            end else begin
              fire_en = 1'b1;
            end
          end
        end
      end
      CMD_REQUEST: begin
        run = (item_i.mode != MODE_IDLE) && (item_i.mode <= MODE_ESTOP_OFF);
        if ((item_i.mode == MODE_POWER_ON) && flags_q[FL_OSC]) begin
          run = 1'b0;
        end
        if ((item_i.mode == MODE_POWER_OFF) && !flags_q[FL_OSC]) begin
          run = 1'b0;
        end
        // emission follows a change-power request at once, filtered or not
        if (item_i.mode == MODE_CHANGE_POWER) begin
          flags_d[FL_EM] = (item_i.power != '0);
        end
        if (run) begin
          if ((last_mode_q == item_i.mode) &&
              ((item_i.mode != MODE_CHANGE_POWER) || (last_power_q == mapped))) begin
            run = 1'b0;
          end else begin
            last_mode_d  = item_i.mode;
            last_power_d = mapped;
          end
        end
        if (!run || blocked_q || (count_q >= FULL_C)) begin
          dropped = 1'b1;
        end else if (step_q == STEP_FREE) begin
          // queue is empty when free: start the request directly
          mode_d  = mode_e'(item_i.mode);
          power_d = mapped;
          wait_d  = '0;
          f_mode  = mode_e'(item_i.mode);
          f_step  = start_step(item_i.mode);
          fire_en = 1'b1;
        end else begin
          push    = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_STOP: begin
        count_d   = '0;
        head_d    = '0;
        step_d    = STEP_FREE;
        wait_d    = '0;
        mode_d    = MODE_IDLE;
        blocked_d = 1'b1;
      end
      CMD_CLEAR_STOP: begin
        blocked_d = 1'b0;
      end
      default: ;
    endcase

    if (fire_en) begin
      case (f_mode)
        MODE_CHANGE_POWER: begin
          case (f_step)
            STEP_BUS_WRITE: begin
              bus_d            = power_d;
              flags_d[FL_SETP] = 1'b1;
              step_d           = STEP_LATCH_RISE;
              wait_d           = cfg_i.latch_setup;
            end
            STEP_LATCH_RISE: begin
              latch_d = 1'b1;
              step_d  = STEP_LATCH_FALL;
              wait_d  = cfg_i.latch_hold;
            end
            STEP_LATCH_FALL: begin
              latch_d = 1'b0;
              if (cfg_i.latch_gap != '0) begin
                step_d = STEP_LATCH_GAP;
                wait_d = cfg_i.latch_gap;
              end else begin
                flags_d[FL_SETP] = 1'b0;
                done             = 1'b1;
              end
            end
            default: begin
              flags_d[FL_SETP] = 1'b0;
              done             = 1'b1;
            end
          endcase
        end
        MODE_POWER_ON: begin
          if (f_step == STEP_ONOFF_FIRST) begin
            flags_d[FL_OSC] = 1'b1;
            step_d          = STEP_ONOFF_SECOND;
            wait_d          = cfg_i.osc_to_em;
          end else begin
            if (f_step == STEP_ONOFF_SECOND) begin
              flags_d[FL_EM] = 1'b1;
            end
            done = 1'b1;
          end
        end
        MODE_POWER_OFF: begin
          if (f_step == STEP_ONOFF_FIRST) begin
            flags_d[FL_EM] = 1'b0;
            step_d         = STEP_ONOFF_SECOND;
            wait_d         = cfg_i.em_to_osc;
          end else begin
            if (f_step == STEP_ONOFF_SECOND) begin
              flags_d[FL_OSC] = 1'b0;
            end
            done = 1'b1;
          end
        end
        MODE_EMISSION_ON: begin
          flags_d[FL_EM] = 1'b1;
          done           = 1'b1;
        end
        MODE_EMISSION_OFF: begin
          flags_d[FL_EM] = 1'b0;
          done           = 1'b1;
        end
        MODE_POINTER_ON: begin
          flags_d[FL_PTR] = 1'b1;
          done            = 1'b1;
        end
        MODE_POINTER_OFF: begin
          flags_d[FL_PTR] = 1'b0;
          done            = 1'b1;
        end
        MODE_ESTOP_ON: begin
          flags_d[FL_STOP] = 1'b1;
          done             = 1'b1;
        end
        MODE_ESTOP_OFF: begin
          flags_d[FL_STOP] = 1'b0;
          done             = 1'b1;
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end

    // request complete: start the inter-request gap
    if (done) begin
      mode_d = MODE_IDLE;
      step_d = STEP_SINGLE;
      wait_d = gap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q       <= '0;
      mode_q       <= MODE_IDLE;
      step_q       <= STEP_FREE;
      power_q      <= '0;
      flags_q      <= '0;
      last_mode_q  <= '0;
      last_power_q <= '0;
      blocked_q    <= 1'b0;
      count_q      <= '0;
      head_q       <= '0;
      bus_q        <= MIN_POWER;
      latch_q      <= 1'b0;
    end else if (en_i) begin
      wait_q       <= wait_d;
      mode_q       <= mode_d;
      step_q       <= step_d;
      power_q      <= power_d;
      flags_q      <= flags_d;
      last_mode_q  <= last_mode_d;
      last_power_q <= last_power_d;
      blocked_q    <= blocked_d;
      count_q      <= count_d;
      head_q       <= head_d;
      bus_q        <= bus_d;
      latch_q      <= latch_d;
    end
  end

  assign we_o         = en_i && push;
  assign waddr_o      = tail[PTR_W-1:0];
  assign wdata_o.mode = item_i.mode;
  assign wdata_o.power = mapped;
  assign raddr_o      = en_i ? head_d : head_q;

  // {dropped, queue_count, busy, status, estop, pointer, emission, oscillator, latch, bus}
  assign result_o = {dropped,
                     QCOUNT_W'(count_d),
                     (step_d != STEP_FREE),
                     item_i.alarm_b, item_i.alarm_a, flags_d,
                     !flags_d[FL_STOP],
                     flags_d[FL_PTR],
                     flags_d[FL_EM],
                     flags_d[FL_OSC],
                     latch_d,
                     bus_d};

endmodule

/* src/fiber_laser_command_sequencer.sv */
// Top level of the fiber laser command sequencer: stream ports, config port, pipeline.
//
// Takes one item per clock on the slave stream and returns exactly one result per item on the
// master stream, in order; with the master side ready, a transfer goes through in every cycle.
// An item is held in the input register until the output register can take its result. All
// filtering, queueing and pin sequencing is evaluated combinationally between the two registers;
// timed sequences advance only on tick items. Waiting requests live in a QUEUE_DEPTH-entry
// memory whose head entry is kept in a registered read port; it needs no clearing after reset.
// Registers must be written over the APB-style port while the block is idle; the block itself
// does not enforce this.
module fiber_laser_command_sequencer #(
  parameter int unsigned QUEUE_DEPTH = flcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [3:0] mode, [11:4] power_level, [12] alarm_a, [13] alarm_b
  input  logic [flcs_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // [1:0] command
  input  logic [flcs_pkg::CMD_W-1:0]       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] power_bus, [8] latch_line, [9] oscillator_enable, [10] emission_modulation,
  // [11] pointer_led, [12] estop_line, [19:13] status_flags, [20] busy_res,
  // [25:21] queue_count, [26] dropped
  output logic [flcs_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [flcs_pkg::PADDR_W-1:0]     paddr,
  input  logic [flcs_pkg::PDATA_W-1:0]     pwdata,
  output logic [flcs_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import flcs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cfg_t             cfg;
  item_t            item_in;
  item_t            item_q;
  logic             in_valid_q, in_valid_d;
  logic             out_valid_q, out_valid_d;
  logic [RES_W-1:0] res_q;
  logic [RES_W-1:0] res;
  logic             advance;
  logic             s_xfer;
  logic             we;
  logic [PTR_W-1:0] waddr, raddr;
  entry_t           wdata, head;

  flcs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign item_in.cmd     = cmd_e'(s_axis_tuser_i);
  assign item_in.mode    = s_axis_tdata_i[3:0];
  assign item_in.power   = s_axis_tdata_i[11:4];
  assign item_in.alarm_a = s_axis_tdata_i[12];
  assign item_in.alarm_b = s_axis_tdata_i[13];

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      item_q <= item_in;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  flcs_core #(
    .DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .head_i   (head),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .raddr_o  (raddr),
    .result_o (res)
  );

  flcs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (head)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - RES_W){1'b0}}, res_q};

endmodule

/* src/flcs_checker.sv */
// Port-level checks for the fiber laser command sequencer, bound to the top level.
module flcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // pins track their status flags
  a_pins_follow_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[9] == m_axis_tdata_o[13]) &&
                        (m_axis_tdata_o[10] == m_axis_tdata_o[14]) &&
                        (m_axis_tdata_o[11] == m_axis_tdata_o[15]) &&
                        (m_axis_tdata_o[12] != m_axis_tdata_o[16]))
    else $error("pin levels disagree with status flags");

  // latch only strobes during a power write
  a_latch_in_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[8]) |-> m_axis_tdata_o[17])
    else $error("latch high outside a power write");

  // queued requests only exist while a sequence or gap runs
  a_queue_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[25:21] != 5'd0)) |-> m_axis_tdata_o[20])
    else $error("requests queued while sequencer free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result transfer changed");

endmodule

bind fiber_laser_command_sequencer flcs_checker u_flcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

/* test/fiber_laser_command_sequencer_tb.sv */
// Self-checking testbench for the fiber laser command sequencer: directed and random streams against a predictor.
module fiber_laser_command_sequencer_tb;
  import flcs_pkg::*;

  typedef struct packed {
    logic              dropped;
    logic [QCOUNT_W-1:0] queue_count;
    logic              busy;
    logic [STATUS_W-1:0] status;
    logic              estop;
    logic              pointer;
    logic              emission;
    logic              osc;
    logic              latch;
    logic [POWER_W-1:0] power_bus;
  } laser_pins_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [CMD_W-1:0]     s_axis_tuser_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  fiber_laser_command_sequencer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // stimulus and checking state
  item_t         feed_q[$];
  item_t         cur_item;
  laser_pins_t   pins_expected_q[$];
  int unsigned   mismatches = 0;
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_stall_pct = 0;
  int unsigned   rx_hold_left = 0;

  // sequencer state as predicted
  logic [TICK_W-1:0]  delay_reg [6] = '{CFG_RESET.osc_to_em, CFG_RESET.em_to_osc,
                                        CFG_RESET.latch_setup, CFG_RESET.latch_hold,
                                        CFG_RESET.latch_gap, CFG_RESET.min_gap};
  logic [TICK_W-1:0]  tick_left = '0;
  logic [MODE_W-1:0]  run_mode = MODE_IDLE;
  logic [STEP_W-1:0]  run_step = STEP_FREE;
  logic [POWER_W-1:0] run_power = '0;
  logic [FLAG_W-1:0]  laser_st = '0;
  logic [MODE_W-1:0]  prev_mode = MODE_IDLE;
  logic [POWER_W-1:0] prev_power = '0;
  logic               starts_held = 1'b0;
  entry_t             waiting_req[$];
  logic [POWER_W-1:0] bus_lvl = MIN_POWER;
  logic               latch_lvl = 1'b0;
  logic               osc_lvl = 1'b0;
  logic               em_lvl = 1'b0;
  logic               ptr_lvl = 1'b0;
  logic               estop_lvl = 1'b1;

  function automatic logic [POWER_W-1:0] scale_power(logic [POWER_W-1:0] raw);
    if (raw == '0) return MIN_POWER;
    if (raw > MAX_POWER) return MAX_POWER;
    if (raw < LOW_POWER_LIMIT) return (raw >> 1) + MIN_POWER;
    return raw;
  endfunction

  // request done: idle gap of at least one tick
  function automatic void end_request();
    run_mode = MODE_IDLE;
    run_step = STEP_SINGLE;
    tick_left = (delay_reg[REG_MIN_GAP] != '0) ? delay_reg[REG_MIN_GAP] : TICK_W'(1);
  endfunction

  function automatic void advance_step();
    case (run_mode)
      MODE_CHANGE_POWER: begin
        if (run_step == STEP_BUS_WRITE) begin
          bus_lvl = run_power;
          laser_st[FL_SETP] = 1'b1;
          run_step = STEP_LATCH_RISE;
          tick_left = delay_reg[REG_LATCH_SETUP];
        end else if (run_step == STEP_LATCH_RISE) begin
          latch_lvl = 1'b1;
          run_step = STEP_LATCH_FALL;
          tick_left = delay_reg[REG_LATCH_HOLD];
        end else if (run_step == STEP_LATCH_FALL && delay_reg[REG_LATCH_GAP] != '0) begin
          latch_lvl = 1'b0;
          run_step = STEP_LATCH_GAP;
          tick_left = delay_reg[REG_LATCH_GAP];
        end else begin
          if (run_step == STEP_LATCH_FALL) latch_lvl = 1'b0;
          laser_st[FL_SETP] = 1'b0;
          end_request();
        end
      end
      MODE_POWER_ON: begin
        if (run_step == STEP_ONOFF_FIRST) begin
          osc_lvl = 1'b1;
          laser_st[FL_OSC] = 1'b1;
          run_step = STEP_ONOFF_SECOND;
          tick_left = delay_reg[REG_OSC_TO_EM];
        end else begin
          if (run_step == STEP_ONOFF_SECOND) begin
            em_lvl = 1'b1;
            laser_st[FL_EM] = 1'b1;
          end
          end_request();
        end
      end
      MODE_POWER_OFF: begin
        if (run_step == STEP_ONOFF_FIRST) begin
          em_lvl = 1'b0;
          laser_st[FL_EM] = 1'b0;
          run_step = STEP_ONOFF_SECOND;
          tick_left = delay_reg[REG_EM_TO_OSC];
        end else begin
          if (run_step == STEP_ONOFF_SECOND) begin
            osc_lvl = 1'b0;
            laser_st[FL_OSC] = 1'b0;
          end
          end_request();
        end
      end
      MODE_EMISSION_ON:  begin em_lvl = 1'b1; laser_st[FL_EM] = 1'b1; end_request(); end
      MODE_EMISSION_OFF: begin em_lvl = 1'b0; laser_st[FL_EM] = 1'b0; end_request(); end
      MODE_POINTER_ON:   begin ptr_lvl = 1'b1; laser_st[FL_PTR] = 1'b1; end_request(); end
      MODE_POINTER_OFF:  begin ptr_lvl = 1'b0; laser_st[FL_PTR] = 1'b0; end_request(); end
      MODE_ESTOP_ON:     begin estop_lvl = 1'b0; laser_st[FL_STOP] = 1'b1; end_request(); end
      MODE_ESTOP_OFF:    begin estop_lvl = 1'b1; laser_st[FL_STOP] = 1'b0; end_request(); end
      default: end_request();
    endcase
  endfunction

  function automatic void start_next();
    entry_t e;
    if (waiting_req.size() == 0 || starts_held) return;
    e = waiting_req.pop_front();
    run_mode = e.mode;
    run_power = e.power;
    if (e.mode == MODE_CHANGE_POWER) begin
      run_step = STEP_BUS_WRITE;
    end else if (e.mode == MODE_POWER_ON || e.mode == MODE_POWER_OFF) begin
      run_step = STEP_ONOFF_FIRST;
    end else begin
      run_step = STEP_SINGLE;
    end
    tick_left = '0;
    advance_step();
  endfunction

  function automatic logic take_request(logic [MODE_W-1:0] m, logic [POWER_W-1:0] raw);
    logic [POWER_W-1:0] lvl;
    logic               go;
    entry_t             e;
    lvl = scale_power(raw);
    go = (m >= MODE_CHANGE_POWER) && (m <= MODE_ESTOP_OFF);
    if (m == MODE_POWER_ON && laser_st[FL_OSC]) go = 1'b0;
    if (m == MODE_POWER_OFF && !laser_st[FL_OSC]) go = 1'b0;
    // emission follows a power change at once, even if the request is dropped
    if (m == MODE_CHANGE_POWER) begin
      em_lvl = (raw != '0);
      laser_st[FL_EM] = (raw != '0);
    end
    if (go) begin
      if (prev_mode == m && (m != MODE_CHANGE_POWER || prev_power == lvl)) begin
        go = 1'b0;
      end else begin
        prev_mode = m;
        prev_power = lvl;
      end
    end
    if (!go || starts_held || waiting_req.size() >= QUEUE_DEPTH_DEF) return 1'b1;
    e.mode = m;
    e.power = lvl;
    waiting_req.push_back(e);
    if (run_step == STEP_FREE) start_next();
    return 1'b0;
  endfunction

  function automatic laser_pins_t predict_pins(item_t it);
    laser_pins_t r;
    logic        rejected;
    rejected = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        if (run_step != STEP_FREE) begin
          if (tick_left > 1) begin
            tick_left = tick_left - 1'b1;
          end else begin
            tick_left = '0;
            if (run_mode == MODE_IDLE) begin
              run_step = STEP_FREE;
              start_next();
            end else begin
              advance_step();
            end
          end
        end
      end
      CMD_REQUEST: rejected = take_request(it.mode, it.power);
      CMD_STOP: begin
        waiting_req.delete();
        run_step = STEP_FREE;
        tick_left = '0;
        run_mode = MODE_IDLE;
        starts_held = 1'b1;
      end
      default: starts_held = 1'b0;
    endcase
    r.power_bus = bus_lvl;
    r.latch = latch_lvl;
    r.osc = osc_lvl;
    r.emission = em_lvl;
    r.pointer = ptr_lvl;
    r.estop = estop_lvl;
    r.status = {it.alarm_b, it.alarm_a, laser_st};
    r.busy = (run_step != STEP_FREE);
    r.queue_count = QCOUNT_W'(waiting_req.size());
    r.dropped = rejected;
    return r;
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) pins_expected_q.push_back(predict_pins(cur_item));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_item = feed_q.pop_front();
          s_axis_tdata_i <= {2'b00, cur_item.alarm_b, cur_item.alarm_a, cur_item.power,
                             cur_item.mode};
          s_axis_tuser_i <= cur_item.cmd;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver readiness, with an optional long hold-off
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : result_mon
    laser_pins_t want;
    laser_pins_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = laser_pins_t'(m_axis_tdata_o[RES_W-1:0]);
      if (pins_expected_q.size() == 0) begin
        mismatches++;
        $error("unexpected result transfer: %h", m_axis_tdata_o);
      end else begin
        want = pins_expected_q.pop_front();
        check_field("power_bus", want.power_bus, got.power_bus);
        check_field("latch_line", want.latch, got.latch);
        check_field("oscillator_enable", want.osc, got.osc);
        check_field("emission_modulation", want.emission, got.emission);
        check_field("pointer_led", want.pointer, got.pointer);
        check_field("estop_line", want.estop, got.estop);
        check_field("status_flags", want.status, got.status);
        check_field("busy_res", want.busy, got.busy);
        check_field("queue_count", want.queue_count, got.queue_count);
        check_field("dropped", want.dropped, got.dropped);
      end
    end
  end

  task automatic write_delay(reg_e idx, logic [TICK_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(idx));
    pwdata <= PDATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    delay_reg[idx] = val;
  endtask

  task automatic queue_item(cmd_e c, logic [MODE_W-1:0] m, logic [POWER_W-1:0] p);
    item_t it;
    it.cmd = c;
    it.mode = m;
    it.power = p;
    it.alarm_a = 1'($urandom);
    it.alarm_b = 1'($urandom);
    feed_q.push_back(it);
  endtask

  task automatic queue_random(int unsigned n);
    item_t       it;
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      it.mode = MODE_W'($urandom);
      it.power = POWER_W'($urandom);
      it.alarm_a = 1'($urandom);
      it.alarm_b = 1'($urandom);
      pick = $urandom_range(99);
      if (pick < 55) begin
        it.cmd = CMD_TICK;
      end else if (pick < 93) begin
        it.cmd = CMD_REQUEST;
        if ($urandom_range(19) != 0) begin
          it.mode = MODE_W'($urandom_range(MODE_ESTOP_OFF, MODE_CHANGE_POWER));
        end
        case ($urandom_range(11))
          0: it.power = '0;
          1: it.power = LOW_POWER_LIMIT - 1'b1;
          2: it.power = LOW_POWER_LIMIT;
          3: it.power = MAX_POWER;
          4: it.power = MAX_POWER + 1'b1;
          5: it.power = '1;
          default: ;
        endcase
      end else if (pick < 96) begin
        it.cmd = CMD_STOP;
      end else begin
        it.cmd = CMD_CLEAR_STOP;
      end
      feed_q.push_back(it);
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (feed_q.size() != 0 || s_axis_tvalid_i || pins_expected_q.size() != 0);
  endtask

  initial begin
    logic [TICK_W-1:0] v;
    wait (rst_ni);
    @(posedge clk_i);
    write_delay(REG_OSC_TO_EM, TICK_W'(2));
    write_delay(REG_EM_TO_OSC, TICK_W'(1));
    write_delay(REG_LATCH_SETUP, TICK_W'(1));
    write_delay(REG_LATCH_HOLD, TICK_W'(1));
    write_delay(REG_LATCH_GAP, TICK_W'(1));
    write_delay(REG_MIN_GAP, TICK_W'(0));

    @(negedge clk_i);
    queue_item(CMD_TICK, MODE_IDLE, '0);
    queue_item(CMD_REQUEST, MODE_IDLE, '0);
    queue_item(CMD_REQUEST, '1, '0);
    queue_item(CMD_REQUEST, MODE_POWER_OFF, '1);
    queue_item(CMD_REQUEST, MODE_CHANGE_POWER, '0);
    queue_item(CMD_REQUEST, MODE_CHANGE_POWER, '0);
    queue_item(CMD_REQUEST, MODE_CHANGE_POWER, '1);
    queue_item(CMD_REQUEST, MODE_CHANGE_POWER, LOW_POWER_LIMIT - 1'b1);
    queue_item(CMD_REQUEST, MODE_CHANGE_POWER, LOW_POWER_LIMIT);
    queue_item(CMD_REQUEST, MODE_CHANGE_POWER, MAX_POWER);
    queue_item(CMD_REQUEST, MODE_POWER_ON, '0);
    queue_item(CMD_REQUEST, MODE_POWER_ON, '0);
    queue_item(CMD_REQUEST, MODE_POINTER_ON, '0);
    queue_item(CMD_REQUEST, MODE_ESTOP_ON, '0);
    queue_item(CMD_REQUEST, MODE_ESTOP_OFF, '0);
    queue_item(CMD_REQUEST, MODE_EMISSION_ON, '0);
    queue_item(CMD_REQUEST, MODE_EMISSION_OFF, '0);
    queue_item(CMD_REQUEST, MODE_POINTER_OFF, '0);
    repeat (4) queue_item(CMD_TICK, MODE_IDLE, '0);
    queue_item(CMD_STOP, MODE_IDLE, '0);
    queue_item(CMD_REQUEST, MODE_CHANGE_POWER, 8'd100);
    queue_item(CMD_CLEAR_STOP, MODE_IDLE, '0);
    queue_item(CMD_TICK, MODE_IDLE, '0);
    drain();

    for (int unsigned ph = 0; ph < 10; ph++) begin
      for (int r = 0; r < 6; r++) begin
        case (ph)
          0: v = '0;
          4: v = TICK_W'(1000000);
          7: v = TICK_W'($urandom_range(1000000));
          default: v = TICK_W'($urandom_range(3));
        endcase
        write_delay(reg_e'(r), v);
      end
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
        default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
      endcase
      @(negedge clk_i);
      if (ph == 2) begin
        // back-to-back power changes while busy: fills the request queue and overflows it
        tx_idle_pct = 0;
        queue_item(CMD_CLEAR_STOP, MODE_IDLE, '0);
        for (int unsigned k = 0; k < 20; k++) queue_item(CMD_REQUEST, MODE_CHANGE_POWER, 8'(60 + k));
        rx_hold_left = 300;
      end
      queue_random(100);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
